// ===== rtl/core/prc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_pkg: shared definitions for the point rotation block
// Widths, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int unsigned COORD_WIDTH_DEF  = 24;
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ANGLE_W          = 16;
  localparam int unsigned TRIG_W           = 32;
  localparam int unsigned TRIG_FRAC        = 30;
  localparam int unsigned ATAN_ENTRIES     = 24;
  localparam int unsigned PREP_STAGES      = 3;
  localparam int unsigned ROT_STAGES       = 3;

  // A full turn is 23040 angle units. The binary angle is a * 2^23 / 45,
  // split into a * 186413 + floor(a * 23 / 45).
  localparam int unsigned FULL_TURN   = 23040;
  localparam int unsigned RED_W       = 15;
  localparam int unsigned TURN_MUL    = 186413;
  localparam int unsigned FRAC_MUL    = 34300107;
  localparam int unsigned FRAC_MUL_W  = 26;
  localparam int unsigned FRAC_SHIFT  = 26;
  localparam int unsigned CORDIC_GAIN = 652032874;

  typedef logic signed [TRIG_W-1:0] trig_t;

  localparam trig_t ATAN_TAB [ATAN_ENTRIES] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

endpackage

// ===== rtl/core/prc_angle_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_angle_prep: angle reduction and binary angle conversion
// Three stages: reduce modulo a full turn, scale to a 32-bit binary angle,
// then fold the left half plane onto the right one.
// ----------------------------------------------------------------------------
module prc_angle_prep (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [prc_pkg::ANGLE_W-1:0]  angle_i,
  input  logic                                rev_i,
  output prc_pkg::trig_t                      z_o,
  output logic                                flip_o
);
  import prc_pkg::*;

  localparam logic signed [17:0] FULL_S = 18'(FULL_TURN);
  localparam logic signed [17:0] TWO_S  = 18'(2 * FULL_TURN);

  logic signed [17:0]      ang_s;
  logic signed [17:0]      red_s;
  logic [RED_W-1:0]        a_q;
  logic [RED_W+17:0]       p1_full;
  logic [RED_W+FRAC_MUL_W-1:0] p2_full;
  logic [TRIG_W-1:0]       p1_q;
  logic [RED_W-1:0]        q_q;
  logic [TRIG_W-1:0]       theta;
  logic                    flip_d;
  trig_t                   z_d;
  trig_t                   z_q;
  logic                    flip_q;

  always_comb begin
    ang_s = 18'(angle_i);
    if (rev_i) begin
      ang_s = -ang_s;
    end
    priority if (ang_s < -FULL_S) begin
      red_s = ang_s + TWO_S;
    end else if (ang_s < 18'sd0) begin
      red_s = ang_s + FULL_S;
    end else if (ang_s >= FULL_S) begin
      red_s = ang_s - FULL_S;
    end else begin
      red_s = ang_s;
    end
  end

  assign p1_full = {18'b0, a_q} * (RED_W+18)'(TURN_MUL);
  assign p2_full = {{FRAC_MUL_W{1'b0}}, a_q} * (RED_W+FRAC_MUL_W)'(FRAC_MUL);

  always_comb begin
    theta  = p1_q + {{(TRIG_W-RED_W){1'b0}}, q_q};
    flip_d = (theta[TRIG_W-1] != theta[TRIG_W-2]);
    z_d    = flip_d ? {~theta[TRIG_W-1], theta[TRIG_W-2:0]} : theta;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= red_s[RED_W-1:0];
      p1_q   <= p1_full[TRIG_W-1:0];
      q_q    <= p2_full[FRAC_SHIFT+RED_W-1:FRAC_SHIFT];
      z_q    <= z_d;
      flip_q <= flip_d;
    end
  end

  assign z_o    = z_q;
  assign flip_o = flip_q;

endmodule

// ===== rtl/core/prc_cordic_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_cordic_cell: one rotation-mode CORDIC iteration
// Holds one step's x, y and residual angle and passes them to the next cell.
// ----------------------------------------------------------------------------
module prc_cordic_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  prc_pkg::trig_t x_i,
  input  prc_pkg::trig_t y_i,
  input  prc_pkg::trig_t z_i,
  input  logic           flip_i,
  output prc_pkg::trig_t x_o,
  output prc_pkg::trig_t y_o,
  output prc_pkg::trig_t z_o,
  output logic           flip_o
);
  import prc_pkg::*;

  trig_t xs, ys, x_d, y_d, z_d;
  trig_t x_q, y_q, z_q;
  logic  flip_q;

  always_comb begin
    xs = x_i >>> SHIFT;
    ys = y_i >>> SHIFT;
    if (!z_i[TRIG_W-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN_TAB[SHIFT];
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN_TAB[SHIFT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      flip_q <= flip_i;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign flip_o = flip_q;

endmodule

// ===== rtl/core/prc_rotate_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_rotate_out: applies cosine and sine to the offset from the center
// Stages: sign fold, four products, rounded sums; then shift, re-add the
// center and saturate to the coordinate range.
// ----------------------------------------------------------------------------
module prc_rotate_out #(
  parameter int unsigned COORD_WIDTH = prc_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  prc_pkg::trig_t                x_i,
  input  prc_pkg::trig_t                y_i,
  input  logic                          flip_i,
  input  logic signed [COORD_WIDTH-1:0] cx_i,
  input  logic signed [COORD_WIDTH-1:0] cy_i,
  input  logic signed [COORD_WIDTH:0]   dx_i,
  input  logic signed [COORD_WIDTH:0]   dy_i,
  output logic signed [COORD_WIDTH-1:0] rx_o,
  output logic signed [COORD_WIDTH-1:0] ry_o
);
  import prc_pkg::*;

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = DW + TRIG_W;
  localparam int unsigned AW = PW + 2;
  localparam int unsigned SH = AW - TRIG_FRAC;
  localparam int unsigned TW = SH + 1;
  localparam logic signed [AW-1:0] HALF = AW'(1) << (TRIG_FRAC - 1);
  localparam logic signed [TW-1:0] SAT_HI =
    {{(TW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [TW-1:0] SAT_LO = ~SAT_HI;

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
    input logic signed [TW-1:0] v
  );
    logic signed [TW-1:0] r;
    begin
      if (v > SAT_HI) begin
        r = SAT_HI;
      end else if (v < SAT_LO) begin
        r = SAT_LO;
      end else begin
        r = v;
      end
      return r[COORD_WIDTH-1:0];
    end
  endfunction

  trig_t                   c_q, s_q;
  logic signed [DW-1:0]    dx_q, dy_q;
  logic signed [COORD_WIDTH-1:0] cx_q, cy_q, cx_eq, cy_eq, cx_fq, cy_fq;
  logic signed [PW-1:0]    pxc_d, pys_d, pyc_d, pxs_d;
  logic signed [PW-1:0]    pxc_q, pys_q, pyc_q, pxs_q;
  logic signed [AW-1:0]    sx_q, sy_q;
  logic signed [SH-1:0]    shx, shy;
  logic signed [TW-1:0]    totx, toty;

  assign pxc_d = $signed(dx_q) * $signed(c_q);
  assign pys_d = $signed(dy_q) * $signed(s_q);
  assign pyc_d = $signed(dy_q) * $signed(c_q);
  assign pxs_d = $signed(dx_q) * $signed(s_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q   <= flip_i ? -x_i : x_i;
      s_q   <= flip_i ? -y_i : y_i;
      dx_q  <= dx_i;
      dy_q  <= dy_i;
      cx_q  <= cx_i;
      cy_q  <= cy_i;
      pxc_q <= pxc_d;
      pys_q <= pys_d;
      pyc_q <= pyc_d;
      pxs_q <= pxs_d;
      cx_eq <= cx_q;
      cy_eq <= cy_q;
      sx_q  <= AW'(pxc_q) - AW'(pys_q) + HALF;
      sy_q  <= AW'(pyc_q) + AW'(pxs_q) + HALF;
      cx_fq <= cx_eq;
      cy_fq <= cy_eq;
    end
  end

  always_comb begin
    shx  = sx_q[AW-1:TRIG_FRAC];
    shy  = sy_q[AW-1:TRIG_FRAC];
    totx = TW'(shx) + TW'(cx_fq);
    toty = TW'(shy) + TW'(cy_fq);
    rx_o = sat_coord(totx);
    ry_o = sat_coord(toty);
  end

endmodule

// ===== rtl/core/point_rotation_about_center.sv =====
`timescale 1ns / 1ps
// Throughput: one beat per cycle while the skid entry is empty; the CORDIC is a row of CORDIC_STEPS cells, at most 24.
// A two-entry output stage lets one result wait in the skid entry; input beats stall until it drains.
// Reset clears only the valid bits, also those of the output stage; there is no clearing pass.
// ----------------------------------------------------------------------------
// point_rotation_about_center: rotates a point about a center by an angle
// Angle reduction, a pipelined CORDIC for cosine and sine, then rotation of
// the offset, re-adding of the center and saturation.
// ----------------------------------------------------------------------------
module point_rotation_about_center #(
  parameter int unsigned COORD_WIDTH  = prc_pkg::COORD_WIDTH_DEF,
  parameter int unsigned CORDIC_STEPS = prc_pkg::CORDIC_STEPS_DEF,
  localparam int unsigned IN_W  = ((4 * COORD_WIDTH + prc_pkg::ANGLE_W + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // center_x, center_y, target_x, target_y, angle_deg
  input  logic [IN_W-1:0]  s_axis_tdata,
  // reverse_dir
  input  logic             s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // rotated_x, rotated_y
  output logic [OUT_W-1:0] m_axis_tdata
);
  import prc_pkg::*;

  localparam int unsigned NCELL = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int unsigned L     = PREP_STAGES + NCELL;
  localparam int unsigned P     = L + ROT_STAGES;
  localparam int unsigned CW    = COORD_WIDTH;

  logic                 en;
  logic                 accept;
  logic [P-1:0]         vld_q, vld_d;
  logic signed [CW-1:0] in_cx, in_cy, in_tx, in_ty;
  logic signed [ANGLE_W-1:0] in_ang;
  logic signed [CW-1:0] cx_q [L];
  logic signed [CW-1:0] cy_q [L];
  logic signed [CW:0]   dx_q [L];
  logic signed [CW:0]   dy_q [L];
  trig_t                x_w [NCELL+1];
  trig_t                y_w [NCELL+1];
  trig_t                z_w [NCELL+1];
  logic                 f_w [NCELL+1];
  logic signed [CW-1:0] res_x, res_y;
  logic                 ovld_q, ovld_d, skv_q, skv_d;
  logic [2*CW-1:0]      odat_q, odat_d, skd_q, skd_d;

  assign in_cx  = s_axis_tdata[CW-1:0];
  assign in_cy  = s_axis_tdata[2*CW-1:CW];
  assign in_tx  = s_axis_tdata[3*CW-1:2*CW];
  assign in_ty  = s_axis_tdata[4*CW-1:3*CW];
  assign in_ang = s_axis_tdata[4*CW+ANGLE_W-1:4*CW];

  assign en            = !skv_q;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  always_comb begin
    vld_d = vld_q;
    if (en) begin
      vld_d = {vld_q[P-2:0], accept};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q[0] <= in_cx;
      cy_q[0] <= in_cy;
      dx_q[0] <= (CW+1)'(in_tx) - (CW+1)'(in_cx);
      dy_q[0] <= (CW+1)'(in_ty) - (CW+1)'(in_cy);
      for (int j = 1; j < L; j++) begin
        cx_q[j] <= cx_q[j-1];
        cy_q[j] <= cy_q[j-1];
        dx_q[j] <= dx_q[j-1];
        dy_q[j] <= dy_q[j-1];
      end
    end
  end

  prc_angle_prep u_prep (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (in_ang),
    .rev_i   (s_axis_tuser),
    .z_o     (z_w[0]),
    .flip_o  (f_w[0])
  );

  assign x_w[0] = TRIG_W'(CORDIC_GAIN);
  assign y_w[0] = '0;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    prc_cordic_cell #(
      .SHIFT (k)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .x_i    (x_w[k]),
      .y_i    (y_w[k]),
      .z_i    (z_w[k]),
      .flip_i (f_w[k]),
      .x_o    (x_w[k+1]),
      .y_o    (y_w[k+1]),
      .z_o    (z_w[k+1]),
      .flip_o (f_w[k+1])
    );
  end

  prc_rotate_out #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_rot (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (x_w[NCELL]),
    .y_i    (y_w[NCELL]),
    .flip_i (f_w[NCELL]),
    .cx_i   (cx_q[L-1]),
    .cy_i   (cy_q[L-1]),
    .dx_i   (dx_q[L-1]),
    .dy_i   (dy_q[L-1]),
    .rx_o   (res_x),
    .ry_o   (res_y)
  );

  always_comb begin
    ovld_d = ovld_q;
    odat_d = odat_q;
    skv_d  = skv_q;
    skd_d  = skd_q;
    if (skv_q) begin
      if (m_axis_tready) begin
        odat_d = skd_q;
        skv_d  = 1'b0;
      end
    end else if (en && vld_q[P-1]) begin
      if (!ovld_q || m_axis_tready) begin
        odat_d = {res_y, res_x};
        ovld_d = 1'b1;
      end else begin
        skd_d = {res_y, res_x};
        skv_d = 1'b1;
      end
    end else if (m_axis_tready) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
      skv_q  <= 1'b0;
    end else begin
      ovld_q <= ovld_d;
      skv_q  <= skv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    odat_q <= odat_d;
    skd_q  <= skd_d;
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = OUT_W'(odat_q);

endmodule
